// ===== rtl/bpf_pkg.sv =====
// Shared types and constants of the broadphase pair finder.
// Used by every module of the block; depends on nothing.
package bpf_pkg;

   localparam int ID_BITS   = 3;
   localparam int MAX_SLOTS = 8;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_UPDATE  = 2'd2;
   localparam logic [1:0] OP_COMPUTE = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_PRESENT   = 2'd1;
   localparam logic [1:0] ST_ABSENT    = 2'd2;
   localparam logic [1:0] ST_UNBOUNDED = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [2:0]         body_id;
      logic               is_bounded;
      logic               mass_infinite;
      logic               is_active;
      logic signed [31:0] min_x;
      logic signed [31:0] max_x;
      logic signed [31:0] min_y;
      logic signed [31:0] max_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_z;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic       pair_valid;
      logic [2:0] first_id;
      logic [2:0] second_id;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic present;
      logic bounded;
      logic infinite;
      logic active;
   } slot_flags_type;

   typedef struct packed {
      logic clear;
      logic write;
      logic start;
      logic step;
      logic pop;
   } merge_ctl_type;

   typedef struct packed {
      logic       ready;
      logic       none;
      logic       last;
      logic [2:0] first_id;
      logic [2:0] second_id;
   } pick_type;

endpackage

// ===== rtl/bpf_lane.sv =====
// One pair-test lane: checks the current row body against this lane's slot.
// Depends on bpf_pkg.
module bpf_lane #(
   parameter int LANE_ID    = 0,
   parameter int NUM_AXES   = 3,
   parameter int COORD_BITS = 32
) (
   input  bpf_pkg::slot_flags_type                row_flags,
   input  bpf_pkg::slot_flags_type                own_flags,
   input  logic [2:0]                             row_id,
   input  logic                                   row_unbounded,
   input  logic [1:0]                             axes_in_use,
   input  logic [NUM_AXES-1:0][COORD_BITS-1:0]    row_lo,
   input  logic [NUM_AXES-1:0][COORD_BITS-1:0]    row_hi,
   input  logic [NUM_AXES-1:0][COORD_BITS-1:0]    own_lo,
   input  logic [NUM_AXES-1:0][COORD_BITS-1:0]    own_hi,
   output logic                                   hit
);

   logic overlap;
   logic row_ok;
   logic own_ok;
   logic keep;
   logic above;

   always_comb begin
      overlap = (axes_in_use != 2'd0);
      for (int a = 0; a < NUM_AXES; a++) begin
         if (2'(a) < axes_in_use) begin
            if ($signed(row_lo[a]) > $signed(own_hi[a]) ||
                $signed(own_lo[a]) > $signed(row_hi[a])) begin
               overlap = 1'b0;
            end
         end
      end
      row_ok = row_flags.present && (row_flags.bounded != row_unbounded);
      own_ok = own_flags.present && own_flags.bounded;
      keep   = !(row_flags.infinite && own_flags.infinite) &&
               (row_flags.active || own_flags.active);
      above  = 3'(LANE_ID) > row_id;
      hit    = row_ok && own_ok && keep && (row_unbounded || (above && overlap));
   end

endmodule

// ===== rtl/bpf_merge.sv =====
// Merging stage: stores the hit mask of each scanned row and hands out the
// pairs in order, one per request. Depends on bpf_pkg.
module bpf_merge #(
   parameter int NSLOT = 8,
   parameter int NROWS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bpf_pkg::merge_ctl_type     ctl,
   input  logic [$clog2(NROWS)-1:0]   wr_row,
   input  logic [NSLOT-1:0]           wr_mask,
   output bpf_pkg::pick_type          pick
);

   localparam int RB = $clog2(NROWS);
   localparam int SB = $clog2(NSLOT);
   localparam int CW = $clog2(NSLOT * NSLOT + 1);

   logic [NSLOT-1:0] mask_ff [NROWS];
   logic [CW-1:0]    count_ff, count_in;
   logic [RB-1:0]    row_ff, row_in;
   logic [NSLOT-1:0] cur_ff, cur_in;
   logic [CW-1:0]    pop_cnt;
   logic [SB-1:0]    low;
   logic [RB-1:0]    nxt_row;
   logic [RB-1:0]    row_slot;

   always_comb begin
      pop_cnt = '0;
      for (int k = 0; k < NSLOT; k++) begin
         pop_cnt = pop_cnt + CW'(wr_mask[k]);
      end
      low = '0;
      for (int k = NSLOT - 1; k >= 0; k--) begin
         if (cur_ff[k]) begin
            low = SB'(k);
         end
      end
      nxt_row  = row_ff + 1'b1;
      row_slot = (row_ff >= RB'(NSLOT)) ? row_ff - RB'(NSLOT) : row_ff;

      count_in = count_ff;
      row_in   = row_ff;
      cur_in   = cur_ff;
      if (ctl.clear) begin
         count_in = '0;
      end
      if (ctl.write) begin
         count_in = count_ff + pop_cnt;
      end
      if (ctl.start) begin
         row_in = '0;
         cur_in = mask_ff[0];
      end
      if (ctl.step) begin
         row_in = nxt_row;
         cur_in = mask_ff[nxt_row];
      end
      if (ctl.pop) begin
         cur_in[low] = 1'b0;
         count_in    = count_ff - 1'b1;
      end

      pick.ready     = |cur_ff;
      pick.none      = (count_ff == '0);
      pick.last      = (count_ff == CW'(1));
      pick.first_id  = 3'(row_slot);
      pick.second_id = 3'(low);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         row_ff   <= '0;
         cur_ff   <= '0;
      end else begin
         count_ff <= count_in;
         row_ff   <= row_in;
         cur_ff   <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         mask_ff[wr_row] <= wr_mask;
      end
   end

endmodule

// ===== rtl/broadphase_pair_finder_unit.sv =====
// Broadphase pair finder: body slot table, one pair-test lane per slot, merging stage.
// Add, remove and update words each give one result word.
// Compute words scan 2*slots rows, one row per cycle, then step past empty rows and
// give one result word per pair, or a single word when there is no pair.
// One word is in work at a time. Synchronous active-high reset empties the table
// and sets axes_in_use to 3; interval storage is not cleared.
module broadphase_pair_finder_unit #(
   parameter int MAX_BODIES = 8,
   parameter int NUM_AXES   = 3,
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bpf_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bpf_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_data
);

   localparam int NSLOT = (MAX_BODIES < bpf_pkg::MAX_SLOTS) ? MAX_BODIES : bpf_pkg::MAX_SLOTS;
   localparam int SB    = $clog2(NSLOT);
   localparam int NROWS = 2 * NSLOT;
   localparam int RB    = $clog2(NROWS);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   typedef logic [NUM_AXES-1:0][COORD_BITS-1:0] coords_type;

   bpf_pkg::slot_flags_type flags_ff [NSLOT];
   bpf_pkg::slot_flags_type flags_in [NSLOT];
   coords_type              lo_ff [NSLOT];
   coords_type              lo_in [NSLOT];
   coords_type              hi_ff [NSLOT];
   coords_type              hi_in [NSLOT];
   logic [1:0]              state_ff, state_in;
   logic [RB-1:0]           row_ff, row_in;
   logic [1:0]              axes_ff, axes_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bpf_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;

   logic                    out_free;
   logic                    req_take;
   logic                    in_range;
   logic [SB-1:0]           slot_idx;
   bpf_pkg::slot_flags_type cur_flags;
   coords_type              new_lo, new_hi;
   logic                    row_unb;
   logic [RB-1:0]           row_full;
   logic [SB-1:0]           row_slot;
   logic [NSLOT-1:0]        hits;
   bpf_pkg::merge_ctl_type  mctl;
   bpf_pkg::pick_type       pick;

   function automatic logic [COORD_BITS-1:0] coord(input logic [31:0] raw);
      logic [63:0] ext;
      ext = {{32{raw[31]}}, raw};
      return ext[COORD_BITS-1:0];
   endfunction

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         unique case (a)
            0: begin
               new_lo[a] = coord(req_word.min_x);
               new_hi[a] = coord(req_word.max_x);
            end
            1: begin
               new_lo[a] = coord(req_word.min_y);
               new_hi[a] = coord(req_word.max_y);
            end
            default: begin
               new_lo[a] = coord(req_word.min_z);
               new_hi[a] = coord(req_word.max_z);
            end
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign in_range  = int'(req_word.body_id) < MAX_BODIES;
   assign slot_idx  = req_word.body_id[SB-1:0];
   assign cur_flags = flags_ff[slot_idx];
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign row_unb  = (row_ff >= RB'(NSLOT));
   assign row_full = row_unb ? row_ff - RB'(NSLOT) : row_ff;
   assign row_slot = row_full[SB-1:0];

   for (genvar j = 0; j < NSLOT; j++) begin : g_lane
      bpf_lane #(
         .LANE_ID   (j),
         .NUM_AXES  (NUM_AXES),
         .COORD_BITS(COORD_BITS)
      ) u_lane (
         .row_flags    (flags_ff[row_slot]),
         .own_flags    (flags_ff[j]),
         .row_id       (3'(row_slot)),
         .row_unbounded(row_unb),
         .axes_in_use  (axes_ff),
         .row_lo       (lo_ff[row_slot]),
         .row_hi       (hi_ff[row_slot]),
         .own_lo       (lo_ff[j]),
         .own_hi       (hi_ff[j]),
         .hit          (hits[j])
      );
   end

   bpf_merge #(
      .NSLOT(NSLOT),
      .NROWS(NROWS)
   ) u_merge (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mctl),
      .wr_row (row_ff),
      .wr_mask(hits),
      .pick   (pick)
   );

   always_comb begin
      flags_in     = flags_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      state_in     = state_ff;
      row_in       = row_ff;
      axes_in      = (csr_valid && csr_ready) ? csr_data : axes_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      mctl         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               rsp_word_in      = '0;
               rsp_word_in.last = 1'b1;
               unique case (req_word.opcode)
                  bpf_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (!in_range) begin
                        rsp_word_in.status = bpf_pkg::ST_ABSENT;
                     end else if (cur_flags.present) begin
                        rsp_word_in.status = bpf_pkg::ST_PRESENT;
                     end else begin
                        rsp_word_in.status       = bpf_pkg::ST_OK;
                        flags_in[slot_idx].present  = 1'b1;
                        flags_in[slot_idx].bounded  = req_word.is_bounded;
                        flags_in[slot_idx].infinite = req_word.mass_infinite;
                        flags_in[slot_idx].active   = req_word.is_active;
                        if (req_word.is_bounded) begin
                           lo_in[slot_idx] = new_lo;
                           hi_in[slot_idx] = new_hi;
                        end
                     end
                  end
                  bpf_pkg::OP_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     if (!in_range || !cur_flags.present) begin
                        rsp_word_in.status = bpf_pkg::ST_ABSENT;
                     end else begin
                        rsp_word_in.status = bpf_pkg::ST_OK;
                        flags_in[slot_idx] = '0;
                     end
                  end
                  bpf_pkg::OP_UPDATE: begin
                     rsp_valid_in = 1'b1;
                     if (!in_range || !cur_flags.present) begin
                        rsp_word_in.status = bpf_pkg::ST_ABSENT;
                     end else if (!cur_flags.bounded) begin
                        rsp_word_in.status = bpf_pkg::ST_UNBOUNDED;
                     end else begin
                        rsp_word_in.status          = bpf_pkg::ST_OK;
                        flags_in[slot_idx].infinite = req_word.mass_infinite;
                        flags_in[slot_idx].active   = req_word.is_active;
                        lo_in[slot_idx]             = new_lo;
                        hi_in[slot_idx]             = new_hi;
                     end
                  end
                  bpf_pkg::OP_COMPUTE: begin
                     rsp_word_in = rsp_word_ff;
                     mctl.clear  = 1'b1;
                     row_in      = '0;
                     state_in    = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            mctl.write = 1'b1;
            row_in     = row_ff + 1'b1;
            if (row_ff == RB'(NROWS - 1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (pick.none) begin
               if (out_free) begin
                  rsp_valid_in     = 1'b1;
                  rsp_word_in      = '0;
                  rsp_word_in.last = 1'b1;
                  state_in         = S_IDLE;
               end
            end else begin
               mctl.start = 1'b1;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!pick.ready) begin
               mctl.step = 1'b1;
            end else if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_word_in.status     = bpf_pkg::ST_OK;
               rsp_word_in.pair_valid = 1'b1;
               rsp_word_in.first_id   = pick.first_id;
               rsp_word_in.second_id  = pick.second_id;
               rsp_word_in.last       = pick.last;
               mctl.pop               = 1'b1;
               if (pick.last) begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         axes_ff      <= 2'd3;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NSLOT; s++) begin
            flags_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         axes_ff      <= axes_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== rtl/bpf_checker.sv =====
// Port-level checks for the broadphase pair finder, bound to the top level.
// Depends on bpf_pkg and broadphase_pair_finder_unit.
module bpf_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input bpf_pkg::rsp_word_type rsp_word
);

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.pair_valid |-> rsp_word.last)
      else $error("A word without a pair must be the last word.");

   a_pair_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.pair_valid |-> rsp_word.status == bpf_pkg::ST_OK)
      else $error("A pair word must carry status ok.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("A stalled result word changed.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

endmodule

bind broadphase_pair_finder_unit bpf_checker u_bpf_checker (.*);

// ===== bench/bpf_checker.sv =====
`timescale 1ns / 1ps
// Checker for the broadphase pair finder: watches the request, result and register channels,
// predicts the result words from its own copy of the slot table and counts mismatches.
// Depends on bpf_pkg.
module tb_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  bpf_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bpf_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_data,
   output int                    fail_count,
   output int                    pending
);

   logic [1:0] axes_setting;
   logic present[8], bounded[8], infinite[8], active[8];
   logic signed [31:0] lo[8][3], hi[8][3];
   bpf_pkg::rsp_word_type expected_words[$];

   task automatic report(input string what, input bpf_pkg::rsp_word_type got,
                         input bpf_pkg::rsp_word_type want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      fail_count++;
   endtask

   task automatic push_word(input logic [1:0] st, input logic pv, input logic [2:0] a,
                            input logic [2:0] b, input logic lst);
      bpf_pkg::rsp_word_type w;
      w.status = st; w.pair_valid = pv; w.first_id = a; w.second_id = b; w.last = lst;
      expected_words.push_back(w);
   endtask

   function automatic logic touching(input int a, input int b, input int axes);
      if (axes == 0) return 1'b0;
      for (int k = 0; k < axes; k++)
         if (lo[a][k] > hi[b][k] || lo[b][k] > hi[a][k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic worth_keeping(input int a, input int b);
      return !(infinite[a] && infinite[b]) && (active[a] || active[b]);
   endfunction

   task automatic store_intervals(input int id, input bpf_pkg::req_word_type r);
      lo[id][0] = r.min_x; hi[id][0] = r.max_x;
      lo[id][1] = r.min_y; hi[id][1] = r.max_y;
      lo[id][2] = r.min_z; hi[id][2] = r.max_z;
   endtask

   task automatic predict_pairs(input bpf_pkg::req_word_type r);
      int id, axes, found;
      bpf_pkg::rsp_word_type tail;
      id = int'(r.body_id);
      case (r.opcode)
         bpf_pkg::OP_ADD: begin
            if (present[id]) push_word(bpf_pkg::ST_PRESENT, 1'b0, 3'd0, 3'd0, 1'b1);
            else begin
               present[id] = 1'b1; bounded[id] = r.is_bounded;
               infinite[id] = r.mass_infinite; active[id] = r.is_active;
               if (r.is_bounded) store_intervals(id, r);
               push_word(bpf_pkg::ST_OK, 1'b0, 3'd0, 3'd0, 1'b1);
            end
         end
         bpf_pkg::OP_REMOVE: begin
            if (!present[id]) push_word(bpf_pkg::ST_ABSENT, 1'b0, 3'd0, 3'd0, 1'b1);
            else begin
               present[id] = 1'b0; bounded[id] = 1'b0; infinite[id] = 1'b0; active[id] = 1'b0;
               push_word(bpf_pkg::ST_OK, 1'b0, 3'd0, 3'd0, 1'b1);
            end
         end
         bpf_pkg::OP_UPDATE: begin
            if (!present[id]) push_word(bpf_pkg::ST_ABSENT, 1'b0, 3'd0, 3'd0, 1'b1);
            else if (!bounded[id]) push_word(bpf_pkg::ST_UNBOUNDED, 1'b0, 3'd0, 3'd0, 1'b1);
            else begin
               infinite[id] = r.mass_infinite; active[id] = r.is_active;
               store_intervals(id, r);
               push_word(bpf_pkg::ST_OK, 1'b0, 3'd0, 3'd0, 1'b1);
            end
         end
         default: begin
            axes = (int'(axes_setting) > 3) ? 3 : int'(axes_setting);
            found = 0;
            for (int i = 0; i < 8; i++)
               for (int j = i + 1; j < 8; j++)
                  if (present[i] && bounded[i] && present[j] && bounded[j] &&
                      worth_keeping(i, j) && touching(i, j, axes)) begin
                     push_word(bpf_pkg::ST_OK, 1'b1, 3'(i), 3'(j), 1'b0); found++;
                  end
            for (int i = 0; i < 8; i++)
               for (int j = 0; j < 8; j++)
                  if (present[i] && !bounded[i] && present[j] && bounded[j] &&
                      worth_keeping(i, j)) begin
                     push_word(bpf_pkg::ST_OK, 1'b1, 3'(i), 3'(j), 1'b0); found++;
                  end
            if (found == 0) push_word(bpf_pkg::ST_OK, 1'b0, 3'd0, 3'd0, 1'b1);
            else begin
               tail = expected_words.pop_back();
               tail.last = 1'b1;
               expected_words.push_back(tail);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      bpf_pkg::rsp_word_type want;
      if (reset) begin
         axes_setting <= 2'd3;
         fail_count = 0;
         for (int i = 0; i < 8; i++) begin
            present[i] = 1'b0; bounded[i] = 1'b0; infinite[i] = 1'b0; active[i] = 1'b0;
         end
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) axes_setting <= csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report("unexpected word", rsp_word, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.status !== want.status) report("status", rsp_word, want);
               if (rsp_word.pair_valid !== want.pair_valid) report("pair_valid", rsp_word, want);
               if (rsp_word.first_id !== want.first_id) report("first_id", rsp_word, want);
               if (rsp_word.second_id !== want.second_id) report("second_id", rsp_word, want);
               if (rsp_word.last !== want.last) report("last", rsp_word, want);
            end
         end
         if (req_valid && !req_stall) predict_pairs(req_word);
      end
      pending = expected_words.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the broadphase pair finder testbench: clock, reset, request and register stimulus,
// random result stalls and the verdict. Depends on bpf_pkg, tb_checker and the block.
module tb;

   logic clock = 1'b0, reset = 1'b1;
   logic req_valid = 1'b0, req_stall, rsp_valid, rsp_stall = 1'b0;
   logic csr_valid = 1'b0, csr_ready;
   logic [1:0] csr_data = 2'd3;
   bpf_pkg::req_word_type req_word = '0;
   bpf_pkg::rsp_word_type rsp_word;
   int fail_count, pending;
   int long_hold = 0;
   int rsp_wait = 0;
   logic long_go = 1'b0;
   logic long_seen = 1'b0;

   always #10 clock = ~clock;

   broadphase_pair_finder_unit dut (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .rsp_valid, .rsp_stall, .rsp_word, .csr_valid, .csr_ready, .csr_data
   );

   tb_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall, .rsp_word,
      .csr_valid, .csr_ready, .csr_data, .fail_count, .pending
   );

   function automatic logic signed [31:0] coord_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return $signed($urandom_range(0, 200)) - 100;
      endcase
   endfunction

   task automatic send(input logic [1:0] op, input logic [2:0] id, input logic b,
                       input logic inf, input logic act, input logic random_box);
      bpf_pkg::req_word_type w;
      int idle;
      w.opcode = op; w.body_id = id; w.is_bounded = b; w.mass_infinite = inf;
      w.is_active = act;
      if (random_box) begin
         w.min_x = coord_value(); w.max_x = coord_value();
         w.min_y = coord_value(); w.max_y = coord_value();
         w.min_z = coord_value(); w.max_z = coord_value();
         if ($urandom_range(0, 3) != 0) begin
            if (w.min_x > w.max_x) w.max_x = w.min_x;
            if (w.min_y > w.max_y) w.max_y = w.min_y;
            if (w.min_z > w.max_z) w.max_z = w.min_z;
         end
      end else begin
         w.min_x = 0; w.max_x = 10; w.min_y = 0; w.max_y = 10; w.min_z = 0; w.max_z = 10;
      end
      idle = $urandom_range(0, 5);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_word <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic set_axes(input logic [1:0] value);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (100) @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (long_go && !long_seen) begin
         long_seen <= 1'b1;
         long_hold <= 149;
         rsp_stall <= 1'b1;
      end else if (long_hold > 0) begin
         rsp_stall <= 1'b1;
         long_hold <= long_hold - 1;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid) rsp_wait <= $urandom_range(0, 5);
      end
   end

   initial begin
      logic [1:0] op;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send(bpf_pkg::OP_UPDATE, 3'd0, 1'b1, 1'b0, 1'b1, 1'b1);
      send(bpf_pkg::OP_REMOVE, 3'd7, 1'b0, 1'b0, 1'b0, 1'b1);
      send(bpf_pkg::OP_COMPUTE, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      send(bpf_pkg::OP_ADD, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0);
      send(bpf_pkg::OP_ADD, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0);
      send(bpf_pkg::OP_ADD, 3'd7, 1'b1, 1'b1, 1'b0, 1'b0);
      send(bpf_pkg::OP_ADD, 3'd3, 1'b0, 1'b0, 1'b1, 1'b1);
      send(bpf_pkg::OP_UPDATE, 3'd3, 1'b1, 1'b0, 1'b1, 1'b1);
      send(bpf_pkg::OP_ADD, 3'd5, 1'b1, 1'b1, 1'b1, 1'b1);
      send(bpf_pkg::OP_ADD, 3'd4, 1'b0, 1'b1, 1'b0, 1'b1);
      send(bpf_pkg::OP_COMPUTE, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      send(bpf_pkg::OP_UPDATE, 3'd7, 1'b0, 1'b0, 1'b1, 1'b1);
      send(bpf_pkg::OP_REMOVE, 3'd3, 1'b0, 1'b0, 1'b0, 1'b1);
      for (int i = 0; i < 8; i++) send(bpf_pkg::OP_ADD, 3'(i), 1'b1, 1'b0, 1'b1, 1'b0);
      long_go <= 1'b1;
      send(bpf_pkg::OP_COMPUTE, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send(bpf_pkg::OP_COMPUTE, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send(bpf_pkg::OP_REMOVE, 3'd2, 1'b0, 1'b0, 1'b0, 1'b0);
      for (int phase = 0; phase < 4; phase++) begin
         set_axes(phase == 0 ? 2'd1 : phase == 1 ? 2'd0 : phase == 2 ? 2'd2 : 2'd3);
         for (int n = 0; n < 60; n++) begin
            op = ($urandom_range(0, 9) < 3) ? bpf_pkg::OP_COMPUTE : 2'($urandom_range(0, 2));
            send(op, 3'($urandom_range(0, 7)), $urandom_range(0, 3) != 0,
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
         end
      end
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (200) @(negedge clock);
      if (fail_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb: FAIL");
      $finish;
   end
endmodule
